@@ hdl/tdpt_pkg.sv @@
// Shared constants and types for the trial-division primality tester.
// No dependencies; used by tdpt_rem_unit and trial_division_prime_test.
`default_nettype none

package tdpt_pkg;

   // Width of the candidate number (supported range 2..32)
   localparam int VALUE_WIDTH = 16;
   // Running divisor square; the bound test stops just past sqrt(candidate)
   localparam int SQ_WIDTH    = VALUE_WIDTH + 2;
   // Bit counter of the serial remainder unit (holds VALUE_WIDTH itself)
   localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH + 1);

   // Command to the serial remainder unit
   typedef struct packed {
      logic                   start;
      logic [VALUE_WIDTH-1:0] dividend;
      logic [VALUE_WIDTH-1:0] divisor;
   } tdpt_rem_cmd_type;

   // Status back from the serial remainder unit
   typedef struct packed {
      logic done;
      logic rem_zero;
   } tdpt_rem_status_type;

endpackage

`default_nettype wire

@@ hdl/tdpt_rem_unit.sv @@
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// Depends on tdpt_pkg for widths and the command/status structs.
`default_nettype none

module tdpt_rem_unit
   import tdpt_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire tdpt_rem_cmd_type    cmd,
   output tdpt_rem_status_type      status
);

   logic [VALUE_WIDTH-1:0] shift_ff, shift_in;
   logic [VALUE_WIDTH-1:0] rem_ff,   rem_in;
   logic [VALUE_WIDTH-1:0] div_ff,   div_in;
   logic [CNT_WIDTH-1:0]   cnt_ff,   cnt_in;
   logic                   busy_ff,  busy_in;
   logic                   done_ff,  done_in;
   logic [VALUE_WIDTH:0]   trial;

   // Partial remainder with the next dividend bit shifted in
   assign trial = {rem_ff, shift_ff[VALUE_WIDTH-1]};

   // One restoring step per cycle while busy
   always_comb begin
      shift_in = shift_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (cmd.start) begin
         shift_in = cmd.dividend;
         div_in   = cmd.divisor;
         rem_in   = '0;
         cnt_in   = CNT_WIDTH'(VALUE_WIDTH);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         shift_in = {shift_ff[VALUE_WIDTH-2:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            rem_in = VALUE_WIDTH'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[VALUE_WIDTH-1:0];
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_WIDTH'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
      cnt_ff   <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign status.done     = done_ff;
   assign status.rem_zero = (rem_ff == '0);

endmodule

`default_nettype wire

@@ hdl/trial_division_prime_test.sv @@
// Trial-division primality tester: top level with control sequencer.
// Depends on tdpt_pkg and tdpt_rem_unit.
//
// Tests one unsigned candidate at a time and returns one is_prime result per
// transaction. Candidates 0 and 1 go straight from the take to the hand-off. Otherwise
// divisors d = 2, 3, ... are tried while d*d <= candidate, with d*d kept as a
// running sum. Each tried divisor passes through a bound check, a start, the
// VALUE_WIDTH serial remainder steps of the single bit-serial remainder unit
// and a status check; around these come taking the candidate, the final bound
// check and the result hand-off.
// For 16-bit candidates that is at most 254 divisors.
// req_stall is high while a candidate is in work; a finished result waits in
// the output register, so a new candidate can be taken while it is pending.
`default_nettype none

module trial_division_prime_test
   import tdpt_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [VALUE_WIDTH-1:0] req_candidate,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic                        rsp_is_prime
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_FINISH
   } state_type;

   state_type              state_ff,   state_in;
   logic [VALUE_WIDTH-1:0] n_ff,       n_in;
   logic [VALUE_WIDTH-1:0] d_ff,       d_in;
   logic [SQ_WIDTH-1:0]    sq_ff,      sq_in;
   logic                   prime_ff,   prime_in;
   logic                   start_ff,   start_in;
   logic                   rsp_vld_ff, rsp_vld_in;
   logic                   rsp_bit_ff, rsp_bit_in;

   tdpt_rem_cmd_type       rem_cmd;
   tdpt_rem_status_type    rem_status;
   logic                   req_take;
   logic                   rsp_free;

   assign req_take = req_valid && (state_ff == ST_IDLE);
   assign rsp_free = !rsp_vld_ff || !rsp_stall;

   // Sequencer: bound check, serial remainder, next divisor
   always_comb begin
      state_in   = state_ff;
      n_in       = n_ff;
      d_in       = d_ff;
      sq_in      = sq_ff;
      prime_in   = prime_ff;
      start_in   = 1'b0;
      rsp_vld_in = rsp_vld_ff && rsp_stall;
      rsp_bit_in = rsp_bit_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               n_in  = req_candidate;
               d_in  = VALUE_WIDTH'(2);
               sq_in = SQ_WIDTH'(4);
               if (req_candidate < VALUE_WIDTH'(2)) begin
                  prime_in = 1'b0;
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (sq_ff <= {2'b00, n_ff}) begin
               start_in = 1'b1;
               state_in = ST_DIV;
            end else begin
               prime_in = 1'b1;
               state_in = ST_FINISH;
            end
         end
         ST_DIV: begin
            if (rem_status.done) begin
               if (rem_status.rem_zero) begin
                  prime_in = 1'b0;
                  state_in = ST_FINISH;
               end else begin
                  // (d+1)^2 = d^2 + 2d + 1
                  sq_in    = sq_ff + SQ_WIDTH'({d_ff, 1'b1});
                  d_in     = d_ff + 1'b1;
                  state_in = ST_CHECK;
               end
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_vld_in = 1'b1;
               rsp_bit_in = prime_ff;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      n_ff       <= n_in;
      d_ff       <= d_in;
      sq_ff      <= sq_in;
      prime_ff   <= prime_in;
      rsp_bit_ff <= rsp_bit_in;
      if (reset) begin
         state_ff   <= ST_IDLE;
         start_ff   <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         start_ff   <= start_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Serial remainder of candidate by current divisor
   assign rem_cmd.start    = start_ff;
   assign rem_cmd.dividend = n_ff;
   assign rem_cmd.divisor  = d_ff;

   tdpt_rem_unit u_rem (
      .clock  (clock),
      .reset  (reset),
      .cmd    (rem_cmd),
      .status (rem_status)
   );

   assign req_stall    = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_vld_ff;
   assign rsp_is_prime = rsp_bit_ff;

endmodule

`default_nettype wire

@@ test/tb_trial_division_prime_test.sv @@
// Testbench for trial_division_prime_test: directed and random candidates,
// each checked against a behavioral trial-division predictor.
// Depends on tdpt_pkg and the trial_division_prime_test RTL.

module tb_trial_division_prime_test
   import tdpt_pkg::*;
();

   localparam int CLOCK_PERIOD  = 10;
   localparam int RANDOM_ITEMS  = 118;
   // Watchdog limit; several times the slowest run
   localparam int CYCLE_LIMIT   = 3_000_000;
   localparam int DRAIN_CYCLES  = 100;
   localparam int HOLD_START    = 3000;
   localparam int HOLD_CYCLES   = 6000;

   typedef struct {
      logic [VALUE_WIDTH-1:0] candidate;
      logic                   is_prime;
   } primality_result_type;

   logic                   clock         = 1'b0;
   logic                   reset         = 1'b1;
   logic                   req_valid     = 1'b0;
   logic                   req_stall;
   logic [VALUE_WIDTH-1:0] req_candidate = '0;
   logic                   rsp_valid;
   logic                   rsp_stall     = 1'b0;
   logic                   rsp_is_prime;

   logic [VALUE_WIDTH-1:0] pending_candidates[$];
   primality_result_type   expected_primality[$];
   int unsigned            candidate_total = 0;
   int unsigned            accepted_count  = 0;
   int unsigned            mismatch_count  = 0;
   int unsigned            cycle_count     = 0;

   trial_division_prime_test u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_candidate (req_candidate),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_is_prime  (rsp_is_prime)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Primality by trial division; divisor and square kept wide so the bound never wraps
   function automatic logic primality_of(logic [VALUE_WIDTH-1:0] n);
      longint unsigned value;
      longint unsigned divisor;
      value = 64'(n);
      if (value < 2) return 1'b0;
      for (divisor = 2; divisor * divisor <= value; divisor++) begin
         if (value % divisor == 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   // Sender: bursts of random length separated by random gaps
   always @(posedge clock) begin : driver
      int unsigned          burst_left;
      int unsigned          gap_left;
      logic                 accepted;
      primality_result_type entry;
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left = $urandom_range(1, 20);
         gap_left   = 0;
      end else begin
         accepted = req_valid && !req_stall;
         if (accepted) begin
            entry.candidate = req_candidate;
            entry.is_prime  = primality_of(req_candidate);
            expected_primality.push_back(entry);
            accepted_count++;
         end
         // A stalled transaction holds its payload
         if (!req_valid || accepted) begin
            if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_candidates.size() != 0) begin
               req_valid     <= 1'b1;
               req_candidate <= pending_candidates.pop_front();
               burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 20);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: quiet windows, random stalls, and one long hold-off to back up the block
   always @(posedge clock) begin : receiver
      int unsigned rx_cycle;
      int unsigned hold_left;
      rx_cycle++;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else if (rx_cycle == HOLD_START) begin
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (rx_cycle[7:6] == 2'b00) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 2) == 0);
      end
   end

   // Result checker: compare each transaction with the oldest expectation
   always @(posedge clock) begin : monitor
      primality_result_type entry;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_primality.size() == 0) begin
            $display("%0t: unexpected result, expected none, got is_prime=%0b",
                     $time, rsp_is_prime);
            mismatch_count++;
         end else begin
            entry = expected_primality.pop_front();
            if (rsp_is_prime !== entry.is_prime) begin
               $display("%0t: candidate %0d is_prime expected %0b, got %0b",
                        $time, entry.candidate, entry.is_prime, rsp_is_prime);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding",
                  $time, expected_primality.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Stimulus and end of run
   initial begin : stimulus
      logic [VALUE_WIDTH-1:0] directed_values[$];
      int unsigned            kind;
      int unsigned            root;
      // Zero and one, two and three, small squares, field extremes, largest primes
      directed_values = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd9, 16'd25,
                          16'd49, 16'd65535, 16'd65521, 16'd65025, 16'd63001,
                          16'd32768, 16'd32749, 16'd1021, 16'd1024, 16'h5555,
                          16'hAAAA, 16'd65534, 16'd121, 16'd7};
      foreach (directed_values[i]) pending_candidates.push_back(directed_values[i]);
      // Random part: mostly small candidates, some full width, some perfect squares
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         kind = $urandom_range(0, 9);
         if (kind <= 5) begin
            pending_candidates.push_back(VALUE_WIDTH'($urandom_range(0, 1023)));
         end else if (kind <= 8) begin
            pending_candidates.push_back(VALUE_WIDTH'($urandom_range(0, 65535)));
         end else begin
            root = $urandom_range(2, 255);
            pending_candidates.push_back(VALUE_WIDTH'(root * root));
         end
      end
      candidate_total = pending_candidates.size();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (accepted_count != candidate_total || expected_primality.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/tdpt_pkg.sv
hdl/tdpt_rem_unit.sv
hdl/trial_division_prime_test.sv
test/tb_trial_division_prime_test.sv
